// ===== src/c3zp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the 3x3 zero-padded convolution stream.
package c3zp_pkg;

    localparam int KSIZE     = 3;
    localparam int COEF_W    = 8;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;
    localparam int GEOM_W    = 11;
    localparam int FV_W      = 20;

    localparam int MIN_SIZE   = 3;
    localparam int MAX_HEIGHT = 1024;
    localparam int GEOM_MAX   = (1 << GEOM_W) - 1;

    localparam logic [CFG_W-1:0]  KERNEL_TOP_RST = 24'h000100;
    localparam logic [CFG_W-1:0]  KERNEL_MID_RST = 24'h01FC01;
    localparam logic [CFG_W-1:0]  KERNEL_BOT_RST = 24'h000100;
    localparam logic [GEOM_W-1:0] WIDTH_RST      = 11'd640;
    localparam logic [GEOM_W-1:0] HEIGHT_RST     = 11'd480;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KERNEL_TOP    = 3'd0,
        CFG_KERNEL_MIDDLE = 3'd1,
        CFG_KERNEL_BOTTOM = 3'd2,
        CFG_IMAGE_WIDTH   = 3'd3,
        CFG_IMAGE_HEIGHT  = 3'd4
    } cfg_reg_e;

    typedef struct packed {
        logic emit;
        logic left;
        logic right;
        logic top;
        logic bottom;
        logic last;
    } pos_flags_t;

    typedef struct packed {
        logic             shift;
        logic             cap;
        logic             col_ok;
        logic [KSIZE-1:0] row_ok;
    } cell_ctrl_t;

endpackage

// ===== src/conv3x3_zero_pad_stream.sv =====
`timescale 1ns / 1ps
// Streaming 3x3 convolution with zero padding: top level.
//
// Pixels enter in raster order on the input channel (in_valid, in_stall), one word per
// pixel; a word with drain set is a zero pixel. After a frame of width * height pixels
// the user sends width + 1 drain words, and the result for each pixel comes out on the
// output channel (out_valid, out_stall) once the word one row plus one pixel later is
// taken. The result of the frame's last pixel carries frame_last, and the position
// counters then restart at pixel (0,0).
// The pipeline takes one word per clock while in_stall is low. A result passes through
// the line store read, window cell shift, per-column products and final sum registers
// before it is valid on the output.
// The rate is set by the window cells, which shift one column per word, and by the line
// store, which is read once and written once per word.
// The user must write the kernel and geometry registers through the cfg port only while
// the block is idle, which it does not enforce; a width or height write restarts the frame.
// Reset restores the default Laplacian kernel and a 640 x 480 frame and empties the
// pipeline. The line store is not cleared: entries left from an earlier frame fall outside
// the image and are masked. When out_stall holds a result, the stages behind it keep
// filling until they are full, and only then does in_stall rise.
module conv3x3_zero_pad_stream #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [PIXEL_BITS-1:0]               pixel_in,
    input  logic                                drain,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [c3zp_pkg::FV_W-1:0]    filtered_value,
    output logic                                frame_last,
    input  logic                                cfg_wr_en,
    input  logic [c3zp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [c3zp_pkg::CFG_W-1:0]          cfg_data
);
    import c3zp_pkg::*;

    localparam int AW       = $clog2(MAX_WIDTH);
    localparam int WIDTH_HI = (MAX_WIDTH < GEOM_MAX) ? MAX_WIDTH : GEOM_MAX;
    localparam int CMP_W    = (AW + 1 > GEOM_W) ? AW + 1 : GEOM_W;
    localparam int LS_W     = 2 * PIXEL_BITS;

    logic [CFG_W-1:0]  kernel_top_reg, kernel_top_next;
    logic [CFG_W-1:0]  kernel_mid_reg, kernel_mid_next;
    logic [CFG_W-1:0]  kernel_bot_reg, kernel_bot_next;
    logic [GEOM_W-1:0] width_reg, width_next;
    logic [GEOM_W-1:0] height_reg, height_next;
    logic [AW-1:0]     col_reg, col_next;
    logic [GEOM_W-1:0] row_reg, row_next;

    logic [GEOM_W-1:0] geom_val;
    logic [GEOM_W-1:0] width_clamped;
    logic [GEOM_W-1:0] height_clamped;
    logic [GEOM_W-1:0] h_plus1;
    logic [AW:0]       col_inc;
    logic              col_zero;
    logic              col_wrap;
    pos_flags_t        acc_flags;
    logic [PIXEL_BITS-1:0] pix_acc;

    logic                  valid_a_reg;
    logic [PIXEL_BITS-1:0] pix_a_reg;
    logic [AW-1:0]         col_a_reg;
    pos_flags_t            flags_a_reg;
    logic                  valid_w_reg;
    pos_flags_t            flags_w_reg;
    logic                  valid_p_reg;
    logic                  last_p_reg;
    logic                  out_valid_reg;
    logic signed [FV_W-1:0] filtered_value_reg;
    logic signed [FV_W-1:0] filtered_value_next;
    logic                  frame_last_reg;

    logic acc;
    logic rdy_a, rdy_w, rdy_p, rdy_o;
    logic mv_a, mv_w, mv_p, cap_w;

    logic [LS_W-1:0]       ls_rd;
    logic [PIXEL_BITS-1:0] up_pix;
    logic [PIXEL_BITS-1:0] lo_pix;

    cell_ctrl_t                            cell_ctrl [KSIZE];
    logic [KSIZE-1:0][COEF_W-1:0]          cell_coef [KSIZE];
    logic [KSIZE-1:0][PIXEL_BITS-1:0]      cell_in   [KSIZE];
    logic [KSIZE-1:0][PIXEL_BITS-1:0]      cell_out  [KSIZE];
    logic signed [FV_W-1:0]                cell_psum [KSIZE];

    // Handshake through the pipeline; a stage moves when the one after it has room.
    assign rdy_o    = !out_valid_reg || !out_stall;
    assign mv_p     = valid_p_reg && rdy_o;
    assign rdy_p    = !valid_p_reg || rdy_o;
    assign mv_w     = valid_w_reg && rdy_p;
    assign cap_w    = mv_w && flags_w_reg.emit;
    assign rdy_w    = !valid_w_reg || rdy_p;
    assign mv_a     = valid_a_reg && rdy_w;
    assign rdy_a    = !valid_a_reg || rdy_w;
    assign in_stall = !rdy_a;
    assign acc      = in_valid && rdy_a;

    always_comb
    begin
        geom_val = cfg_data[GEOM_W-1:0];
        if (geom_val < GEOM_W'(MIN_SIZE))
        begin
            width_clamped  = GEOM_W'(MIN_SIZE);
            height_clamped = GEOM_W'(MIN_SIZE);
        end
        else
        begin
            width_clamped  = (geom_val > GEOM_W'(WIDTH_HI)) ? GEOM_W'(WIDTH_HI) : geom_val;
            height_clamped = (geom_val > GEOM_W'(MAX_HEIGHT)) ? GEOM_W'(MAX_HEIGHT) : geom_val;
        end
    end

    always_comb
    begin
        h_plus1  = height_reg + GEOM_W'(1);
        col_zero = (col_reg == '0);
        col_inc  = {1'b0, col_reg} + (AW + 1)'(1);
        col_wrap = CMP_W'(col_inc) >= CMP_W'(width_reg);
        pix_acc  = (drain || (row_reg >= height_reg)) ? '0 : pixel_in;

        if (col_zero)
        begin
            acc_flags.emit   = (row_reg >= GEOM_W'(2)) && (row_reg <= h_plus1);
            acc_flags.left   = 1'b1;
            acc_flags.right  = 1'b0;
            acc_flags.top    = row_reg >= GEOM_W'(3);
            acc_flags.bottom = row_reg <= height_reg;
            acc_flags.last   = row_reg == h_plus1;
        end
        else
        begin
            acc_flags.emit   = (row_reg >= GEOM_W'(1)) && (row_reg <= height_reg);
            acc_flags.left   = col_reg >= AW'(2);
            acc_flags.right  = 1'b1;
            acc_flags.top    = row_reg >= GEOM_W'(2);
            acc_flags.bottom = row_reg < height_reg;
            acc_flags.last   = 1'b0;
        end
    end

    always_comb
    begin
        kernel_top_next = kernel_top_reg;
        kernel_mid_next = kernel_mid_reg;
        kernel_bot_next = kernel_bot_reg;
        width_next      = width_reg;
        height_next     = height_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_KERNEL_TOP:    kernel_top_next = cfg_data;
                CFG_KERNEL_MIDDLE: kernel_mid_next = cfg_data;
                CFG_KERNEL_BOTTOM: kernel_bot_next = cfg_data;
                CFG_IMAGE_WIDTH:
                begin
                    width_next = width_clamped;
                    col_next   = '0;
                    row_next   = '0;
                end
                CFG_IMAGE_HEIGHT:
                begin
                    height_next = height_clamped;
                    col_next    = '0;
                    row_next    = '0;
                end
                default: ;
            endcase
        end
        else if (acc)
        begin
            if (acc_flags.last)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (col_wrap)
            begin
                col_next = '0;
                row_next = row_reg + GEOM_W'(1);
            end
            else
            begin
                col_next = col_inc[AW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_top_reg <= KERNEL_TOP_RST;
            kernel_mid_reg <= KERNEL_MID_RST;
            kernel_bot_reg <= KERNEL_BOT_RST;
            width_reg      <= WIDTH_RST;
            height_reg     <= HEIGHT_RST;
            col_reg        <= '0;
            row_reg        <= '0;
            valid_a_reg    <= 1'b0;
            valid_w_reg    <= 1'b0;
            valid_p_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            kernel_top_reg <= kernel_top_next;
            kernel_mid_reg <= kernel_mid_next;
            kernel_bot_reg <= kernel_bot_next;
            width_reg      <= width_next;
            height_reg     <= height_next;
            col_reg        <= col_next;
            row_reg        <= row_next;

            if (acc)
            begin
                valid_a_reg <= 1'b1;
            end
            else if (mv_a)
            begin
                valid_a_reg <= 1'b0;
            end

            if (mv_a)
            begin
                valid_w_reg <= 1'b1;
            end
            else if (mv_w)
            begin
                valid_w_reg <= 1'b0;
            end

            if (cap_w)
            begin
                valid_p_reg <= 1'b1;
            end
            else if (mv_p)
            begin
                valid_p_reg <= 1'b0;
            end

            if (mv_p)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign filtered_value_next = cell_psum[0] + cell_psum[1] + cell_psum[2];

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            pix_a_reg   <= pix_acc;
            col_a_reg   <= col_reg;
            flags_a_reg <= acc_flags;
        end
        if (mv_a)
        begin
            flags_w_reg <= flags_a_reg;
        end
        if (cap_w)
        begin
            last_p_reg <= flags_w_reg.last;
        end
        if (mv_p)
        begin
            filtered_value_reg <= filtered_value_next;
            frame_last_reg     <= last_p_reg;
        end
    end

    c3zp_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW),
        .DW    (LS_W)
    ) u_line_store (
        .clk     (clk),
        .rd_en   (acc),
        .rd_addr (col_reg),
        .rd_data (ls_rd),
        .wr_en   (mv_a),
        .wr_addr (col_a_reg),
        .wr_data ({lo_pix, pix_a_reg})
    );

    assign up_pix = ls_rd[LS_W-1:PIXEL_BITS];
    assign lo_pix = ls_rd[PIXEL_BITS-1:0];

    for (genvar j = 0; j < KSIZE; j++)
    begin : g_cell
        logic col_ok;

        if (j == 0)
        begin : g_left
            assign col_ok = flags_w_reg.left;
        end
        else if (j == KSIZE - 1)
        begin : g_right
            assign col_ok = flags_w_reg.right;
        end
        else
        begin : g_mid
            assign col_ok = 1'b1;
        end

        if (j == KSIZE - 1)
        begin : g_feed
            assign cell_in[j] = {pix_a_reg, lo_pix, up_pix};
        end
        else
        begin : g_chain
            assign cell_in[j] = cell_out[j+1];
        end

        assign cell_ctrl[j] = '{shift:  mv_a,
                                cap:    cap_w,
                                col_ok: col_ok,
                                row_ok: {flags_w_reg.bottom, 1'b1, flags_w_reg.top}};

        assign cell_coef[j] = {kernel_bot_reg[COEF_W*j +: COEF_W],
                               kernel_mid_reg[COEF_W*j +: COEF_W],
                               kernel_top_reg[COEF_W*j +: COEF_W]};

        c3zp_cell #(
            .PIXEL_BITS (PIXEL_BITS)
        ) u_cell (
            .clk     (clk),
            .ctrl    (cell_ctrl[j]),
            .coef    (cell_coef[j]),
            .pix_in  (cell_in[j]),
            .pix_out (cell_out[j]),
            .psum    (cell_psum[j])
        );
    end

    assign out_valid      = out_valid_reg;
    assign filtered_value = filtered_value_reg;
    assign frame_last     = frame_last_reg;

    a_last_restarts_frame: assert property (@(posedge clk) disable iff (!rst_n)
        acc && acc_flags.last |=> (col_reg == '0) && (row_reg == '0))
        else $error("position counters did not restart after the frame's last word");

    a_row_in_tail: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= h_plus1)
        else $error("row counter ran past the drain tail");

    // At a frame restart column zero may be read and written together; that entry is masked.
    a_store_no_collision: assert property (@(posedge clk) disable iff (!rst_n)
        acc && mv_a && !col_zero |-> col_a_reg != col_reg)
        else $error("line store read and write hit the same column in one cycle");

endmodule

// ===== src/c3zp_line_store.sv =====
`timescale 1ns / 1ps
// Line store memory holding the two previous rows, one word per column.
module c3zp_line_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 16
) (
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data
);
    logic [DW-1:0] line_mem_reg [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            line_mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= line_mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/c3zp_cell.sv =====
`timescale 1ns / 1ps
// Window cell: holds one window column and forms its masked partial sum.
module c3zp_cell #(
    parameter int PIXEL_BITS = 8
) (
    input  logic                                                 clk,
    input  c3zp_pkg::cell_ctrl_t                                 ctrl,
    input  logic [c3zp_pkg::KSIZE-1:0][c3zp_pkg::COEF_W-1:0]     coef,
    input  logic [c3zp_pkg::KSIZE-1:0][PIXEL_BITS-1:0]           pix_in,
    output logic [c3zp_pkg::KSIZE-1:0][PIXEL_BITS-1:0]           pix_out,
    output logic signed [c3zp_pkg::FV_W-1:0]                     psum
);
    import c3zp_pkg::*;

    localparam int PROD_W = PIXEL_BITS + COEF_W + 1;

    logic [KSIZE-1:0][PIXEL_BITS-1:0] pix_reg;
    logic signed [FV_W-1:0]           psum_reg;
    logic signed [FV_W-1:0]           psum_next;
    logic [PIXEL_BITS-1:0]            tap [KSIZE];
    logic signed [PROD_W-1:0]         prod [KSIZE];

    always_comb
    begin
        psum_next = '0;
        for (int r = 0; r < KSIZE; r++)
        begin
            tap[r]    = (ctrl.col_ok && ctrl.row_ok[r]) ? pix_reg[r] : '0;
            prod[r]   = $signed(coef[r]) * $signed({1'b0, tap[r]});
            psum_next = psum_next + FV_W'(prod[r]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            pix_reg <= pix_in;
        end
        if (ctrl.cap)
        begin
            psum_reg <= psum_next;
        end
    end

    assign pix_out = pix_reg;
    assign psum    = psum_reg;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the streaming 3x3 zero-padded convolution, with its own predictor.
module tb_top;
    import c3zp_pkg::*;

    localparam int MAX_W        = 1024;
    localparam int PIX_W        = 8;
    localparam int SETTLE       = 12;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_WORDS = 420;
    localparam int HOLD_AT      = 250;
    localparam int HOLD_LEN     = 150;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic             drn;
    } pixel_word_t;

    typedef struct {
        logic signed [FV_W-1:0] value;
        logic                   last;
    } conv_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [PIX_W-1:0]       pixel_in = '0;
    logic                   drain = 1'b0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic signed [FV_W-1:0] filtered_value;
    logic                   frame_last;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]       cfg_data = '0;

    pixel_word_t  pixel_words[$];
    conv_result_t expected_sums[$];
    int errors = 0;
    int words_in = 0;
    int cycles = 0;

    logic [CFG_W-1:0] kern [KSIZE];
    int               img_w;
    int               img_h;
    logic [PIX_W-1:0] line_upper [MAX_W];
    logic [PIX_W-1:0] line_lower [MAX_W];
    logic [PIX_W-1:0] win [KSIZE][KSIZE];
    int               col_cnt;
    int               row_cnt;

    pixel_word_t  next_word;
    conv_result_t want;
    int burst_left = 0;
    int gap_left = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int stall_mode = 0;
    int mode_left = 0;

    conv3x3_zero_pad_stream #(.MAX_WIDTH(MAX_W), .PIXEL_BITS(PIX_W)) dut (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void convolve_step(input logic [PIX_W-1:0] pix_in, input logic drn);
        int col;
        int row;
        int cx;
        int cy;
        int sum;
        int k;
        logic [PIX_W-1:0] pix;
        logic [PIX_W-1:0] up;
        logic [PIX_W-1:0] lo;
        conv_result_t res;
        col = col_cnt;
        row = row_cnt;
        if (col >= MAX_W)
            col = 0;
        pix = (drn || row >= img_h) ? '0 : pix_in;
        up = line_upper[col];
        lo = line_lower[col];
        line_upper[col] = lo;
        line_lower[col] = pix;
        for (int r = 0; r < KSIZE; r++)
        begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2] = up;
        win[1][2] = lo;
        win[2][2] = pix;
        if (col >= 1)
        begin
            cx = col - 1;
            cy = row - 1;
        end
        else
        begin
            cx = img_w - 1;
            cy = row - 2;
        end
        col++;
        if (col >= img_w)
        begin
            col = 0;
            row++;
        end
        col_cnt = col;
        row_cnt = row;
        if (cy < 0 || cy >= img_h)
            return;
        sum = 0;
        for (int r = 0; r < KSIZE; r++)
        begin
            for (int c = 0; c < KSIZE; c++)
            begin
                if (cy + r - 1 >= 0 && cy + r - 1 < img_h && cx + c - 1 >= 0 && cx + c - 1 < img_w)
                begin
                    k = $signed(kern[r][COEF_W*c +: COEF_W]);
                    sum += k * int'(win[r][c]);
                end
            end
        end
        res.value = sum[FV_W-1:0];
        res.last = (cx == img_w - 1) && (cy == img_h - 1);
        if (res.last)
        begin
            col_cnt = 0;
            row_cnt = 0;
        end
        expected_sums.push_back(res);
    endfunction

    function automatic void set_register(input cfg_reg_e idx, input logic [CFG_W-1:0] val);
        int g;
        g = val[GEOM_W-1:0];
        g = (g < MIN_SIZE) ? MIN_SIZE : g;
        case (idx)
            CFG_KERNEL_TOP:    kern[0] = val;
            CFG_KERNEL_MIDDLE: kern[1] = val;
            CFG_KERNEL_BOTTOM: kern[2] = val;
            CFG_IMAGE_WIDTH:
            begin
                img_w = (g > MAX_W) ? MAX_W : g;
                col_cnt = 0;
                row_cnt = 0;
            end
            CFG_IMAGE_HEIGHT:
            begin
                img_h = (g > MAX_HEIGHT) ? MAX_HEIGHT : g;
                col_cnt = 0;
                row_cnt = 0;
            end
            default: ;
        endcase
    endfunction

    function automatic void push_word(input logic [PIX_W-1:0] p, input logic d);
        pixel_words.push_back('{pix: p, drn: d});
    endfunction

    function automatic logic [CFG_W-1:0] pick_kernel_row();
        case ($urandom_range(0, 5))
            0:       return 24'h808080;
            1:       return 24'h7F7F7F;
            default: return CFG_W'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        errors++;
    endtask

    task automatic write_reg(input cfg_reg_e idx, input logic [CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        set_register(idx, val);
        @(posedge clk);
    endtask

    task automatic program_frame(input logic [CFG_W-1:0] top, input logic [CFG_W-1:0] mid,
                                 input logic [CFG_W-1:0] bot, input logic [CFG_W-1:0] wdata,
                                 input logic [CFG_W-1:0] hdata);
        write_reg(CFG_KERNEL_TOP, top);
        write_reg(CFG_KERNEL_MIDDLE, mid);
        write_reg(CFG_KERNEL_BOTTOM, bot);
        write_reg(CFG_IMAGE_WIDTH, wdata);
        write_reg(CFG_IMAGE_HEIGHT, hdata);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (pixel_words.size() != 0 || in_valid || expected_sums.size() != 0);
    endtask

    task automatic wait_idle();
        wait_drained();
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic queue_frame(input int count, input bit pause_mid);
        int span;
        int pos;
        pixel_word_t word;
        span = img_w * img_h + img_w + 1;
        for (int i = 0; i < count; i++)
        begin
            pos = i % span;
            if (pos < img_w * img_h)
            begin
                word.drn = ($urandom_range(0, 19) == 0);
                case ($urandom_range(0, 7))
                    0:       word.pix = '0;
                    1:       word.pix = '1;
                    default: word.pix = PIX_W'($urandom);
                endcase
            end
            else
            begin
                word.drn = ($urandom_range(0, 5) != 0);
                word.pix = PIX_W'($urandom);
            end
            pixel_words.push_back(word);
            if (pause_mid && i == count / 2)
                wait_drained();
        end
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("FAIL conv3x3_zero_pad_stream");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
            begin
                convolve_step(pixel_in, drain);
                words_in++;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pixel_words.size() != 0)
                begin
                    next_word = pixel_words.pop_front();
                    in_valid <= 1'b1;
                    pixel_in <= next_word.pix;
                    drain <= next_word.drn;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(0, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_sums.size() == 0)
                    report_mismatch($sformatf("unexpected word, filtered_value %0d",
                                              filtered_value));
                else
                begin
                    want = expected_sums.pop_front();
                    if (filtered_value !== want.value)
                        report_mismatch($sformatf("filtered_value got %0d expected %0d",
                                                  filtered_value, want.value));
                    if (frame_last !== want.last)
                        report_mismatch($sformatf("frame_last got %0b expected %0b",
                                                  frame_last, want.last));
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (!hold_done && words_in >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN;
                out_stall <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(10, 80);
                end
                else
                    mode_left--;
                case (stall_mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    default: out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    initial
    begin
        int queued;
        int count;
        int wraw;
        int hraw;
        for (int i = 0; i < MAX_W; i++)
        begin
            line_upper[i] = '0;
            line_lower[i] = '0;
        end
        foreach (win[r, c])
            win[r][c] = '0;
        kern[0] = KERNEL_TOP_RST;
        kern[1] = KERNEL_MID_RST;
        kern[2] = KERNEL_BOT_RST;
        img_w = WIDTH_RST;
        img_h = HEIGHT_RST;
        col_cnt = 0;
        row_cnt = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Smallest frame, all weights at -128 and all pixels at full scale.
        program_frame(24'h808080, 24'h808080, 24'h808080, 24'd3, 24'd3);
        for (int i = 0; i < 9; i++)
            push_word('1, 1'b0);
        for (int i = 0; i < 4; i++)
            push_word('0, 1'b1);
        wait_idle();

        // Laplacian, a drain inside the frame, a pixel in the drain tail and a drain after
        // the frame end.
        program_frame(KERNEL_TOP_RST, KERNEL_MID_RST, KERNEL_BOT_RST, 24'd3, 24'd3);
        push_word(8'd0, 1'b0);
        push_word(8'd255, 1'b0);
        push_word(8'd200, 1'b1);
        push_word(8'd255, 1'b0);
        push_word(8'd0, 1'b0);
        push_word(8'd255, 1'b0);
        push_word(8'd0, 1'b0);
        push_word(8'd255, 1'b0);
        push_word(8'd1, 1'b0);
        push_word(8'd0, 1'b1);
        push_word(8'd77, 1'b0);
        push_word(8'd0, 1'b1);
        push_word(8'd0, 1'b1);
        push_word(8'd0, 1'b1);
        wait_idle();

        // Width saturates to the maximum; the frame is cut short by the next write.
        program_frame(pick_kernel_row(), pick_kernel_row(), pick_kernel_row(),
                      {13'($urandom), 11'h7FF}, 24'd3);
        queue_frame(40, 1'b0);
        wait_idle();

        // Height saturates to the maximum; the frame is cut short by the next write.
        program_frame(pick_kernel_row(), pick_kernel_row(), pick_kernel_row(),
                      24'd3, {13'($urandom), 11'd2000});
        queue_frame(40, 1'b0);

        queued = 0;
        while (queued < RANDOM_WORDS)
        begin
            wait_idle();
            wraw = $urandom_range(0, 12);
            hraw = $urandom_range(0, 8);
            program_frame(pick_kernel_row(), pick_kernel_row(), pick_kernel_row(),
                          {13'($urandom), 11'(wraw)}, {13'($urandom), 11'(hraw)});
            count = img_w * img_h + img_w + 1;
            case ($urandom_range(0, 7))
                0:       count = $urandom_range(1, img_w * img_h);
                1:       count = 2 * count;
                2:       count = count + $urandom_range(1, 3);
                default: ;
            endcase
            queue_frame(count, queued == 0 || $urandom_range(0, 4) == 0);
            queued += count;
        end

        wait_idle();
        if (errors == 0)
            $display("PASS conv3x3_zero_pad_stream");
        else
            $display("FAIL conv3x3_zero_pad_stream");
        $finish;
    end

endmodule
